// ----- rtl/core/pep_pkg.sv -----
// shared constants, types and arithmetic helpers for the particle emitter pool
package pep_pkg;

   localparam int POOL_SIZE_DEF = 32;
   localparam int TRIG_SIZE_DEF = 1024;

   localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
   localparam logic [2:0] REG_BASE_HEAD  = 3'd2;
   localparam logic [2:0] REG_SPREAD     = 3'd3;
   localparam logic [2:0] REG_LAUNCH     = 3'd4;
   localparam logic [2:0] REG_LIFETIME   = 3'd5;
   localparam logic [2:0] REG_PERIOD     = 3'd6;
   localparam logic [2:0] REG_FRICTION   = 3'd7;
   localparam int NUM_REGS = 8;

   localparam logic [15:0] LFSR_SEED = 16'hACE1;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;
   localparam logic [15:0] HALF_TURN = 16'h8000;
   localparam logic [15:0] QUARTER_TURN = 16'h4000;

   // datapath commands
   localparam logic [2:0] CMD_NONE    = 3'd0;
   localparam logic [2:0] CMD_FETCH   = 3'd1;
   localparam logic [2:0] CMD_FRICT   = 3'd2;
   localparam logic [2:0] CMD_MOVEX   = 3'd3;
   localparam logic [2:0] CMD_MOVEY   = 3'd4;
   localparam logic [2:0] CMD_WRITE   = 3'd5;
   localparam logic [2:0] CMD_SPAWN   = 3'd6;
   localparam logic [2:0] CMD_ACCUM   = 3'd7;

   typedef struct packed {
      logic [2:0] op;
      logic [5:0] slot;
      logic       clear_tick;
   } cmd_type;

   typedef struct packed {
      logic alive;
      logic acc_ge;
   } stat_type;

   // q16 sine of table entry idx of n entries per turn, used to fill the table
   function automatic logic signed [17:0] trig_entry(input int idx, input int n);
      longint four, q, r, num, step, x, x2, t, mag;
      four = longint'(idx) * 4;
      // quadrant and position inside it
      q = 0;
      r = four;
      while (r >= longint'(n)) begin
         r = r - longint'(n);
         q = q + 1;
      end
      // restoring long division for (r * 65536) / n
      num = r * 65536;
      x = 0;
      for (int b = 16; b >= 0; b--) begin
         step = longint'(n) <<< b;
         if (num >= step) begin
            num = num - step;
            x = x + (longint'(1) <<< b);
         end
      end
      if (q[0]) x = 65536 - x;
      x2 = (x * x) >>> 16;
      t = (5223 * x2) >>> 16;
      t = ((42334 - t) * x2) >>> 16;
      mag = ((102944 - t) * x) >>> 16;
      if (mag > 65536) mag = 65536;
      if (q[1]) mag = -mag;
      return 18'(mag);
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

endpackage

// ----- rtl/core/pep_if.sv -----
// valid/ready stream channel carrying a generic payload
interface pep_if #(parameter int W = 32);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/pep_dp.sv -----
// pool storage, per slot arithmetic and spawn logic
module pep_dp #(
   parameter int POOL_SIZE = pep_pkg::POOL_SIZE_DEF,
   parameter int TRIG_SIZE = pep_pkg::TRIG_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  pep_pkg::cmd_type  cmd,
   output pep_pkg::stat_type stat,
   input  logic [31:0]       elapsed_time,
   input  logic              csr_we,
   input  logic [2:0]        csr_idx,
   input  logic [31:0]       csr_wdata,
   output logic [31:0]       o_pos_x,
   output logic [31:0]       o_pos_y,
   output logic [15:0]       o_heading,
   output logic [31:0]       o_speed,
   output logic [31:0]       o_age,
   output logic [6:0]        o_spawned,
   output logic              o_full,
   output logic              o_alive
);
   localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int TW = $clog2(TRIG_SIZE);

   logic [31:0] origin_x_ff, origin_y_ff, launch_ff, life_ff, period_ff, frict_ff;
   logic [15:0] base_ff, spread_ff;

   logic [31:0] mem_x [POOL_SIZE];
   logic [31:0] mem_y [POOL_SIZE];
   logic [15:0] mem_h [POOL_SIZE];
   logic [31:0] mem_s [POOL_SIZE];
   logic [31:0] mem_a [POOL_SIZE];
   logic [POOL_SIZE-1:0] valid_ff;

   logic [31:0] x_ff, y_ff, sp_ff, age_ff;
   logic [15:0] h_ff;
   logic [31:0] acc_ff;
   logic [31:0] t_ff;
   logic [15:0] lfsr_ff;
   logic [6:0]  spawned_ff;
   logic        full_ff;
   logic [AW-1:0] idx;

   assign idx = AW'(cmd.slot);

   // entry defaults for slots never written since reset
   logic [31:0] rd_x, rd_y, rd_s, rd_a;
   logic [15:0] rd_h;
   always_comb begin
      rd_x = valid_ff[idx] ? mem_x[idx] : '0;
      rd_y = valid_ff[idx] ? mem_y[idx] : '0;
      rd_h = valid_ff[idx] ? mem_h[idx] : '0;
      rd_s = valid_ff[idx] ? mem_s[idx] : '0;
      rd_a = valid_ff[idx] ? mem_a[idx] : 32'hFFFF_FFFF;
   end

   // friction loss (one multiply, registered)
   logic [63:0] loss_prod;
   logic [47:0] loss_ff;
   assign loss_prod = 64'(frict_ff) * 64'(t_ff);

   // sine table filled at elaboration, read with a registered output
   logic signed [17:0] trig_rom [TRIG_SIZE];
   initial begin
      for (int i = 0; i < TRIG_SIZE; i++) trig_rom[i] = pep_pkg::trig_entry(i, TRIG_SIZE);
   end

   // trig lookup: cosine address before movex, sine address during movex
   logic [15:0] trig_h;
   logic [TW-1:0] tidx;
   logic signed [17:0] trig_ff;
   logic [16:0] trig_mag;
   logic [48:0] mv_prod;
   logic signed [33:0] mv_delta, mv_sum;
   logic [31:0] mv_res;
   logic [31:0] cur_pos;

   always_comb begin
      trig_h = (cmd.op == pep_pkg::CMD_MOVEX) ? h_ff : h_ff + pep_pkg::QUARTER_TURN;
      tidx = TW'((32'(trig_h) * TRIG_SIZE) >> 16);
   end

   always_ff @(posedge clock) begin
      trig_ff <= trig_rom[tidx];
   end

   always_comb begin
      trig_mag = trig_ff[17] ? 17'(-trig_ff) : trig_ff[16:0];
      mv_prod = 49'(trig_mag) * 49'(sp_ff);
      mv_delta = trig_ff[17] ? -34'(mv_prod[48:16]) : 34'(mv_prod[48:16]);
      cur_pos = (cmd.op == pep_pkg::CMD_MOVEX) ? x_ff : y_ff;
      mv_sum = 34'($signed(cur_pos)) + mv_delta;
      if (mv_sum > 34'sh7FFF_FFFF) mv_res = 32'h7FFF_FFFF;
      else if (mv_sum < -34'sh8000_0000) mv_res = 32'h8000_0000;
      else mv_res = mv_sum[31:0];
   end

   // jitter
   logic [15:0] lfsr_nx;
   logic signed [16:0] off;
   logic signed [33:0] jprod;
   logic [15:0] new_h;
   always_comb begin
      lfsr_nx = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? pep_pkg::LFSR_TAPS : 16'h0);
      off = $signed({1'b0, lfsr_nx}) - 17'sd32768;
      jprod = 34'(off) * $signed({18'b0, spread_ff});
      new_h = base_ff + jprod[31:16];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0; origin_y_ff <= '0; base_ff <= '0; spread_ff <= '0;
         launch_ff <= 32'd65536; life_ff <= 32'd65536; period_ff <= 32'd6554;
         frict_ff <= '0; acc_ff <= '0; lfsr_ff <= pep_pkg::LFSR_SEED;
         valid_ff <= '0; spawned_ff <= '0; full_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_idx)
               pep_pkg::REG_ORIGIN_X:  origin_x_ff <= csr_wdata;
               pep_pkg::REG_ORIGIN_Y:  origin_y_ff <= csr_wdata;
               pep_pkg::REG_BASE_HEAD: base_ff <= csr_wdata[15:0];
               pep_pkg::REG_SPREAD:    spread_ff <= csr_wdata[15:0];
               pep_pkg::REG_LAUNCH:    launch_ff <= csr_wdata;
               pep_pkg::REG_LIFETIME:  life_ff <= csr_wdata;
               pep_pkg::REG_PERIOD:    period_ff <= csr_wdata;
               pep_pkg::REG_FRICTION:  frict_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.clear_tick) begin
            spawned_ff <= '0;
            full_ff <= 1'b0;
         end
         case (cmd.op)
            pep_pkg::CMD_ACCUM: acc_ff <= pep_pkg::sat_add(acc_ff, t_ff);
            pep_pkg::CMD_SPAWN: begin
               if (rd_a >= life_ff) begin
                  valid_ff[idx] <= 1'b1;
                  acc_ff <= acc_ff - period_ff;
                  spawned_ff <= spawned_ff + 7'd1;
                  lfsr_ff <= lfsr_nx;
               end else if (idx == AW'(POOL_SIZE - 1)) begin
                  full_ff <= 1'b1;
               end
            end
            pep_pkg::CMD_WRITE: valid_ff[idx] <= 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      // tick time is held for the whole update pass
      if (cmd.clear_tick) t_ff <= elapsed_time;
      case (cmd.op)
         pep_pkg::CMD_FETCH: begin
            x_ff <= rd_x; y_ff <= rd_y; h_ff <= rd_h; age_ff <= rd_a;
         end
         pep_pkg::CMD_FRICT: begin
            loss_ff <= loss_prod[63:16];
         end
         pep_pkg::CMD_MOVEX: begin
            x_ff <= mv_res;
         end
         pep_pkg::CMD_MOVEY: begin
            y_ff <= mv_res;
         end
         pep_pkg::CMD_WRITE: begin
            mem_x[idx] <= x_ff; mem_y[idx] <= y_ff; mem_h[idx] <= h_ff;
            mem_s[idx] <= sp_ff; mem_a[idx] <= pep_pkg::sat_add(age_ff, t_ff);
         end
         pep_pkg::CMD_SPAWN: begin
            if (rd_a >= life_ff) begin
               mem_x[idx] <= origin_x_ff; mem_y[idx] <= origin_y_ff;
               mem_h[idx] <= new_h; mem_s[idx] <= launch_ff; mem_a[idx] <= '0;
            end
         end
         default: ;
      endcase
   end

   // speed after friction, applied as movex starts
   logic [31:0] sp_new;
   assign sp_new = (48'(sp_ff) <= loss_ff) ? '0 : sp_ff - loss_ff[31:0];

   // the controller inserts a wait state after frict; speed applied via separate step
   logic sp_apply_ff;
   always_ff @(posedge clock) begin
      if (reset) sp_apply_ff <= 1'b0;
      else sp_apply_ff <= (cmd.op == pep_pkg::CMD_FRICT);
   end
   always_ff @(posedge clock) begin
      if (sp_apply_ff) sp_ff <= sp_new;
      else if (cmd.op == pep_pkg::CMD_FETCH) sp_ff <= rd_s;
   end

   always_comb begin
      stat.alive  = rd_a < life_ff;
      stat.acc_ge = acc_ff >= period_ff;
   end

   assign o_alive   = stat.alive;
   assign o_pos_x   = stat.alive ? rd_x : '0;
   assign o_pos_y   = stat.alive ? rd_y : '0;
   assign o_heading = stat.alive ? rd_h : '0;
   assign o_speed   = stat.alive ? rd_s : '0;
   assign o_age     = rd_a;
   assign o_spawned = spawned_ff;
   assign o_full    = full_ff;
endmodule

// ----- rtl/core/pep_ctrl.sv -----
// sequencer: update pass, spawn search, report pass
module pep_ctrl #(
   parameter int POOL_SIZE = pep_pkg::POOL_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_load,
   output logic              out_last,
   input  logic              out_free,
   output pep_pkg::cmd_type  cmd,
   input  pep_pkg::stat_type stat
);
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_FETCH = 4'd1;
   localparam logic [3:0] ST_FRICT = 4'd2;
   localparam logic [3:0] ST_WAIT  = 4'd3;
   localparam logic [3:0] ST_MOVEX = 4'd4;
   localparam logic [3:0] ST_MOVEY = 4'd5;
   localparam logic [3:0] ST_WRITE = 4'd6;
   localparam logic [3:0] ST_ACCUM = 4'd7;
   localparam logic [3:0] ST_SPAWN = 4'd8;
   localparam logic [3:0] ST_RPT   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [5:0] slot_ff, slot_in;
   logic [6:0] nsp_ff, nsp_in;
   localparam logic [5:0] LAST = 6'(POOL_SIZE - 1);

   always_comb begin
      state_in = state_ff; slot_in = slot_ff; nsp_in = nsp_ff;
      cmd = '{op: pep_pkg::CMD_NONE, slot: slot_ff, clear_tick: 1'b0};
      in_ready = 1'b0; out_load = 1'b0; out_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               state_in = ST_FETCH; slot_in = '0; nsp_in = '0;
               cmd.clear_tick = 1'b1;
            end
         end
         ST_FETCH: begin
            cmd.op = pep_pkg::CMD_FETCH;
            if (stat.alive) state_in = ST_FRICT;
            else if (slot_ff == LAST) state_in = ST_ACCUM;
            else slot_in = slot_ff + 6'd1;
         end
         ST_FRICT: begin cmd.op = pep_pkg::CMD_FRICT; state_in = ST_WAIT; end
         ST_WAIT:  state_in = ST_MOVEX;
         ST_MOVEX: begin cmd.op = pep_pkg::CMD_MOVEX; state_in = ST_MOVEY; end
         ST_MOVEY: begin cmd.op = pep_pkg::CMD_MOVEY; state_in = ST_WRITE; end
         ST_WRITE: begin
            cmd.op = pep_pkg::CMD_WRITE;
            if (slot_ff == LAST) state_in = ST_ACCUM;
            else begin slot_in = slot_ff + 6'd1; state_in = ST_FETCH; end
         end
         ST_ACCUM: begin
            cmd.op = pep_pkg::CMD_ACCUM; slot_in = '0; state_in = ST_SPAWN;
         end
         ST_SPAWN: begin
            // lowest dead slot first; restart scan after each spawn
            if (!stat.acc_ge || nsp_ff == 7'(POOL_SIZE)) begin
               state_in = ST_RPT; slot_in = '0;
            end else begin
               cmd.op = pep_pkg::CMD_SPAWN;
               if (!stat.alive) begin
                  nsp_in = nsp_ff + 7'd1; slot_in = '0;
               end else if (slot_ff == LAST) begin
                  state_in = ST_RPT; slot_in = '0;
               end else slot_in = slot_ff + 6'd1;
            end
         end
         ST_RPT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_last = slot_ff == LAST;
               if (slot_ff == LAST) state_in = ST_IDLE;
               else slot_in = slot_ff + 6'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; slot_ff <= '0; nsp_ff <= '0;
      end else begin
         state_ff <= state_in; slot_ff <= slot_in; nsp_ff <= nsp_in;
      end
   end
endmodule

// ----- rtl/core/particle_emitter_pool_step.sv -----
// Particle emitter pool: one elapsed-time beat starts a tick. After the accept state, the
// update pass takes each live slot through fetch, friction, wait, move x, move y and
// write, and each dead slot through fetch only; an accumulate step follows, then the spawn
// search: each spawn rescans from slot 0 up to the dead slot it fills, and the search
// closes on a check of the accumulator or the spawn cap, or with a full scan when no dead
// slot is left. Last come POOL_SIZE report beats, one per cycle unless the result side
// stalls. The cost of a tick is set by the single shared multiply/trig datapath and the
// one slot memory port.
// Configuration writes are taken only while idle.
module particle_emitter_pool_step #(
   parameter int POOL_SIZE = pep_pkg::POOL_SIZE_DEF,
   parameter int TRIG_TABLE_SIZE = pep_pkg::TRIG_SIZE_DEF
) (
   input logic clock,
   input logic reset,
   pep_if.sink   req,
   pep_if.source rsp,
   pep_if.sink   csr
);
   pep_pkg::cmd_type  cmd;
   pep_pkg::stat_type stat;
   logic out_load, out_last, out_free;
   logic [31:0] px, py, sp, ag;
   logic [15:0] hd;
   logic [6:0]  nsp;
   logic        full, alive;

   // register writes only between ticks
   assign csr.ready = req.ready;

   pep_ctrl #(.POOL_SIZE(POOL_SIZE)) u_ctrl (
      .clock, .reset, .in_valid(req.valid), .in_ready(req.ready),
      .out_load, .out_last, .out_free, .cmd, .stat
   );

   pep_dp #(.POOL_SIZE(POOL_SIZE), .TRIG_SIZE(TRIG_TABLE_SIZE)) u_dp (
      .clock, .reset, .cmd, .stat, .elapsed_time(req.data[31:0]),
      .csr_we(csr.valid && csr.ready), .csr_idx(csr.data[34:32]),
      .csr_wdata(csr.data[31:0]),
      .o_pos_x(px), .o_pos_y(py), .o_heading(hd), .o_speed(sp), .o_age(ag),
      .o_spawned(nsp), .o_full(full), .o_alive(alive)
   );

   // output register
   logic         v_ff;
   logic [159:0] d_ff;
   assign out_free = !v_ff || rsp.ready;
   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (out_load) v_ff <= 1'b1;
      else if (rsp.ready) v_ff <= 1'b0;
   end
   always_ff @(posedge clock) begin
      if (out_load) d_ff <= {cmd.slot, alive, px, py, hd, sp, ag, nsp, full, out_last};
   end
   assign rsp.valid = v_ff;
   assign rsp.data  = d_ff;
endmodule

// ----- rtl/core/pep_checker.sv -----
// port-level checks of the emitter pool
module pep_checker (
   input logic clock,
   input logic reset,
   input logic req_valid, req_ready, rsp_valid, rsp_ready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second tick taken");
   a_noout: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !(rsp_valid && !rsp_ready) |=> !rsp_valid)
      else $error("result without work");
endmodule

bind particle_emitter_pool_step pep_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready)
);

// ----- sim/tb_particle_emitter_pool_step.sv -----
// self-checking testbench for the particle emitter pool with its own slot model
module tb_particle_emitter_pool_step;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 32;
   localparam int NTRIG = 1024;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [5:0]  slot;
      logic        alive;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [15:0] heading;
      logic [31:0] speed;
      logic [31:0] age;
      logic [6:0]  spawned;
      logic        full;
      logic        last;
   } report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   pep_if #(.W(32))  req_if ();
   pep_if #(.W(160)) rsp_if ();
   pep_if #(.W(35))  csr_if ();

   particle_emitter_pool_step dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr(csr_if.sink)
   );

   always #4 clock = ~clock;

   // emitter settings as the block should hold them
   logic [31:0] org_x, org_y, launch, life, period, friction;
   logic [15:0] base_hd, spread;
   // pool contents
   logic [31:0] px [NSLOT];
   logic [31:0] py [NSLOT];
   logic [15:0] hd [NSLOT];
   logic [31:0] spd [NSLOT];
   logic [31:0] age [NSLOT];
   logic [31:0] accum;
   logic [15:0] lfsr;

   logic [31:0] pending_ticks [$];
   report_type  expected_reports [$];
   int          src_idle = 0, snk_idle = 0;
   int          mismatches = 0;
   int          stall_cycles = 0;

   function automatic longint sine_q16(input logic [15:0] h);
      longint idx, four, q, x, x2, t, mag;
      idx = (longint'(h) * NTRIG) >> 16;
      four = idx * 4;
      q = four / NTRIG;
      x = ((four % NTRIG) * 65536) / NTRIG;
      if (q[0]) x = 65536 - x;
      x2 = (x * x) >> 16;
      t = (5223 * x2) >> 16;
      t = ((42334 - t) * x2) >> 16;
      mag = ((102944 - t) * x) >> 16;
      if (mag > 65536) mag = 65536;
      return q[1] ? -mag : mag;
   endfunction

   function automatic logic [31:0] add_sat(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [31:0] step_coord(input logic [31:0] p, input longint trig,
                                              input logic [31:0] v);
      longint d, s;
      d = ((trig < 0 ? -trig : trig) * longint'(v)) >> 16;
      s = longint'(signed'(p)) + (trig < 0 ? -d : d);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      return s[31:0];
   endfunction

   function automatic logic [15:0] next_heading();
      logic   out;
      longint prod;
      out = lfsr[0];
      lfsr = lfsr >> 1;
      if (out) lfsr = lfsr ^ pep_pkg::LFSR_TAPS;
      prod = (longint'(lfsr) - 32768) * longint'(spread);
      return 16'(longint'(base_hd) + (prod >>> 16));
   endfunction

   task automatic advance_pool(input logic [31:0] t);
      longint     loss;
      int         n, free_slot;
      logic       full;
      report_type r;
      n = 0;
      full = 1'b0;
      loss = (longint'(friction) * longint'(t)) >> 16;
      for (int i = 0; i < NSLOT; i++) begin
         if (age[i] < life) begin
            spd[i] = (loss >= longint'(spd[i])) ? 32'd0 : 32'(longint'(spd[i]) - loss);
            px[i] = step_coord(px[i], sine_q16(hd[i] + pep_pkg::QUARTER_TURN), spd[i]);
            py[i] = step_coord(py[i], sine_q16(hd[i]), spd[i]);
            age[i] = add_sat(age[i], t);
         end
      end
      accum = add_sat(accum, t);
      while (accum >= period && n < NSLOT) begin
         free_slot = -1;
         for (int i = NSLOT - 1; i >= 0; i--)
            if (age[i] >= life) free_slot = i;
         if (free_slot < 0) begin
            full = 1'b1;
            break;
         end
         px[free_slot] = org_x;
         py[free_slot] = org_y;
         hd[free_slot] = next_heading();
         spd[free_slot] = launch;
         age[free_slot] = 32'd0;
         accum = accum - period;
         n++;
      end
      for (int i = 0; i < NSLOT; i++) begin
         r.slot = 6'(i);
         r.alive = age[i] < life;
         r.pos_x = r.alive ? px[i] : 32'd0;
         r.pos_y = r.alive ? py[i] : 32'd0;
         r.heading = r.alive ? hd[i] : 16'd0;
         r.speed = r.alive ? spd[i] : 32'd0;
         r.age = age[i];
         r.spawned = 7'(n);
         r.full = full;
         r.last = (i == NSLOT - 1);
         expected_reports.push_back(r);
      end
   endtask

   // tick driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data <= '0;
      end else begin
         if (req_if.valid && req_if.ready) advance_pool(req_if.data);
         if (!req_if.valid || req_if.ready) begin
            if (pending_ticks.size() > 0 && $urandom_range(99) >= src_idle) begin
               req_if.data <= pending_ticks.pop_front();
               req_if.valid <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // report monitor
   always @(posedge clock) begin
      report_type got, want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= snk_idle);
         if (rsp_if.valid && rsp_if.ready) begin
            got = report_type'(rsp_if.data);
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected report beat %h", got);
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("slot report mismatch: expected %h, got %h", want, got);
               end
            end
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready) || reset) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
      csr_if.data <= {idx, v};
      csr_if.valid <= 1'b1;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      // drop valid so the next write starts on a later edge
      @(posedge clock);
      case (idx)
         pep_pkg::REG_ORIGIN_X:  org_x = v;
         pep_pkg::REG_ORIGIN_Y:  org_y = v;
         pep_pkg::REG_BASE_HEAD: base_hd = v[15:0];
         pep_pkg::REG_SPREAD:    spread = v[15:0];
         pep_pkg::REG_LAUNCH:    launch = v;
         pep_pkg::REG_LIFETIME:  life = v;
         pep_pkg::REG_PERIOD:    period = v;
         default:                friction = v;
      endcase
   endtask

   task automatic drain();
      while (pending_ticks.size() > 0 || req_if.valid || expected_reports.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [31:0] pick32(input logic [31:0] lo, input logic [31:0] hi);
      case ($urandom_range(5))
         0: return lo;
         1: return hi;
         2: return $urandom;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   initial begin
      logic [31:0] t;
      int          nphase;
      csr_if.valid = 1'b0;
      csr_if.data = '0;
      org_x = 0; org_y = 0; base_hd = 0; spread = 0;
      launch = 32'd65536; life = 32'd65536; period = 32'd6554; friction = 0;
      for (int i = 0; i < NSLOT; i++) begin
         px[i] = 0; py[i] = 0; hd[i] = 0; spd[i] = 0; age[i] = 32'hFFFF_FFFF;
      end
      accum = 0;
      lfsr = pep_pkg::LFSR_SEED;
      src_idle = 10;
      snk_idle = 81;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: normal spawning, then a huge step that saturates ages and accumulator
      pending_ticks = '{32'd0, 32'd1, 32'd6554, 32'd20000, 32'd65535, 32'd30000,
                        32'hFFFF_FFFF};
      drain();
      // extreme origin, speed, spread; zero period hits the spawn cap, then pool full
      write_reg(pep_pkg::REG_ORIGIN_X, 32'h7FFF_FFFF);
      write_reg(pep_pkg::REG_ORIGIN_Y, 32'h8000_0000);
      write_reg(pep_pkg::REG_BASE_HEAD, 32'hFFFF);
      write_reg(pep_pkg::REG_SPREAD, 32'hFFFF);
      write_reg(pep_pkg::REG_LAUNCH, 32'hFFFF_FFFF);
      write_reg(pep_pkg::REG_LIFETIME, 32'hFFFF_FFFF);
      write_reg(pep_pkg::REG_PERIOD, 32'd0);
      write_reg(pep_pkg::REG_FRICTION, 32'd0);
      pending_ticks = '{32'd1, 32'd65536, 32'd0, 32'h8000_0000};
      drain();
      // maximum friction slows the live slots, then lifetime zero kills every slot
      write_reg(pep_pkg::REG_FRICTION, 32'hFFFF_FFFF);
      write_reg(pep_pkg::REG_PERIOD, 32'hFFFF_FFFF);
      pending_ticks = '{32'd1, 32'd3};
      drain();
      write_reg(pep_pkg::REG_LIFETIME, 32'd0);
      pending_ticks = '{32'd5, 32'd0};
      drain();
      // longer lifetime revives stored slots
      write_reg(pep_pkg::REG_LIFETIME, 32'h0004_0000);
      write_reg(pep_pkg::REG_FRICTION, 32'd100);
      write_reg(pep_pkg::REG_PERIOD, 32'd40000);
      write_reg(pep_pkg::REG_ORIGIN_X, 32'h0001_0000);
      write_reg(pep_pkg::REG_ORIGIN_Y, 32'hFFFF_0000);
      write_reg(pep_pkg::REG_BASE_HEAD, 32'h4000);
      write_reg(pep_pkg::REG_SPREAD, 32'h8000);
      write_reg(pep_pkg::REG_LAUNCH, 32'h0003_0000);
      pending_ticks = '{32'd10000, 32'd50000, 32'd90000, 32'd20000};
      drain();

      nphase = 12;
      for (int p = 0; p < nphase; p++) begin
         if (p == nphase / 3) begin
            src_idle = 81;
            snk_idle = 10;
         end else if (p == 2 * nphase / 3) begin
            src_idle = 0;
            snk_idle = 0;
         end
         write_reg(pep_pkg::REG_ORIGIN_X, $urandom);
         write_reg(pep_pkg::REG_ORIGIN_Y, $urandom);
         write_reg(pep_pkg::REG_BASE_HEAD, $urandom_range(65535));
         write_reg(pep_pkg::REG_SPREAD, $urandom_range(65535));
         write_reg(pep_pkg::REG_LAUNCH, pick32(32'd0, 32'hFFFF_FFFF));
         write_reg(pep_pkg::REG_LIFETIME, ($urandom_range(7) == 0) ? $urandom
                   : $urandom_range(32'h0010_0000, 32'h0000_8000));
         write_reg(pep_pkg::REG_PERIOD, ($urandom_range(9) == 0) ? $urandom
                   : $urandom_range(32'h0004_0000, 32'h0000_2000));
         write_reg(pep_pkg::REG_FRICTION, pick32(32'd0, 32'h0004_0000));
         for (int k = 0; k < 30; k++) begin
            case ($urandom_range(9))
               0:       t = $urandom;
               1:       t = 32'd0;
               2:       t = 32'hFFFF_FFFF;
               default: t = $urandom_range(32'h0002_0000);
            endcase
            pending_ticks.push_back(t);
         end
         drain();
      end

      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
